FILE: src/sblb_pkg.sv
// Package for the spectrum band bar block: beat types, band edge table,
// log threshold table and the lookup functions built on them. No dependencies.
`default_nettype none

package sblb_pkg;

  localparam int BAND_COUNT = 16;
  localparam int BIN_COUNT  = 256;
  localparam int MAX_HEIGHT = 32;

  localparam int BIN_W    = 8;
  localparam int MAG_W    = 16;
  localparam int PEAK_W   = 15;
  localparam int BAND_W   = 4;
  localparam int HEIGHT_W = 6;

  typedef struct packed {
    logic [BIN_W-1:0]        bin_index;
    logic signed [MAG_W-1:0] magnitude;
  } sblb_in_t;

  typedef struct packed {
    logic [BAND_W-1:0]   band;
    logic [HEIGHT_W-1:0] height;
    logic                last_band;
  } sblb_out_t;

  // Last bin of each band; bin BIN_COUNT-1 belongs to no band.
  localparam logic [BIN_W-1:0] BAND_LAST_BIN [BAND_COUNT] = '{
    8'd0,  8'd1,  8'd2,   8'd4,   8'd6,   8'd9,   8'd13,  8'd19,
    8'd27, 8'd39, 8'd53,  8'd73,  8'd100, 8'd136, 8'd186, 8'd254
  };

  // ceil(2^(3k/7)) for k = 1..32
  localparam logic [PEAK_W-1:0] LOG_THRESH [MAX_HEIGHT] = '{
    15'd2,    15'd2,    15'd3,    15'd4,    15'd5,    15'd6,    15'd8,    15'd11,
    15'd15,   15'd20,   15'd27,   15'd36,   15'd48,   15'd64,   15'd87,   15'd116,
    15'd157,  15'd211,  15'd283,  15'd381,  15'd512,  15'd690,  15'd928,  15'd1249,
    15'd1681, 15'd2262, 15'd3044, 15'd4096, 15'd5513, 15'd7420, 15'd9987, 15'd13441
  };

  typedef struct packed {
    logic              hit;
    logic [BAND_W-1:0] band;
  } sblb_band_t;

  function automatic sblb_band_t band_lookup(input logic [BIN_W-1:0] bin);
    sblb_band_t res;
    res.hit  = 1'b0;
    res.band = '0;
    for (int b = 0; b < BAND_COUNT; b++) begin
      if (bin == BAND_LAST_BIN[b]) begin
        res.hit  = 1'b1;
        res.band = BAND_W'(b);
      end
    end
    return res;
  endfunction

  // Thresholds are monotone, so the highest one met gives the height.
  function automatic logic [HEIGHT_W-1:0] bar_height(input logic [PEAK_W-1:0] peak);
    logic [HEIGHT_W-1:0] h;
    h = '0;
    for (int k = 0; k < MAX_HEIGHT; k++) begin
      if (peak >= LOG_THRESH[k]) begin
        h = HEIGHT_W'(k + 1);
      end
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: src/spectrum_band_log_bars.sv
// Spectrum band bars: bins stream in at one beat per clock unless stalled, one bar
// beat comes out per band end. Two register stages: band decode at the input, peak/height
// at the output. Depends on sblb_pkg.
//
// Usage: one bin beat is taken every clock while the output side keeps up; a bin
// that ends a band becomes a bar beat after the input and output registers. Throughput is
// set by the single output register: while a bar beat waits, bins that end no band
// still move through, and a band-ending bin holds until the bar ahead of it is taken.
// Bins arriving while disabled, and bin 255, are dropped at the input. The running
// peak clears after each bar. Set enable only while the block is idle.
`default_nettype none

module spectrum_band_log_bars
  import sblb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sblb_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output sblb_out_t      out_data
);

  logic              enable_r;
  logic              s1_valid_r;
  logic              s1_hit_r;
  logic [BAND_W-1:0] s1_band_r;
  logic [PEAK_W-1:0] s1_mag_r;
  logic [PEAK_W-1:0] peak_r;
  logic [PEAK_W-1:0] peak_nxt;
  logic              out_valid_r;
  sblb_out_t         out_data_r;

  sblb_band_t        in_band;
  logic              in_keep;
  logic              in_fire;
  logic              s1_fire;
  logic              out_free;

  assign in_band  = band_lookup(in_data.bin_index);
  assign in_keep  = enable_r && (in_data.bin_index != BIN_W'(BIN_COUNT - 1));
  assign out_free = !out_valid_r || out_ready;
  // a beat that ends no band never needs the output register
  assign s1_fire  = s1_valid_r && (out_free || !s1_hit_r);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  // Input stage: drop unwanted beats, clip negatives to zero, decode band end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_fire && in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hit_r  <= in_band.hit;
      s1_band_r <= in_band.band;
      s1_mag_r  <= in_data.magnitude[MAG_W-1] ? '0 : in_data.magnitude[PEAK_W-1:0];
    end
  end

  always_comb begin
    peak_nxt = (s1_mag_r > peak_r) ? s1_mag_r : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (s1_fire) begin
      peak_r <= s1_hit_r ? '0 : peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_hit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_hit_r) begin
      out_data_r.band      <= s1_band_r;
      out_data_r.height    <= bar_height(peak_nxt);
      out_data_r.last_band <= (s1_band_r == BAND_W'(BAND_COUNT - 1));
    end
  end

  a_peak_clears_after_bar: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_hit_r |=> peak_r == '0)
    else $error("peak not cleared after bar beat");

  a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.height <= HEIGHT_W'(MAX_HEIGHT))
    else $error("bar height above maximum");

  a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.last_band == (out_data_r.band == BAND_W'(BAND_COUNT - 1))))
    else $error("last_band flag disagrees with band");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending bar beat overwritten");

  a_disabled_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !enable_r |=> !s1_valid_r)
    else $error("beat kept while disabled");

endmodule

`default_nettype wire
